// File: rtl/bgc_pkg.sv
package bgc_pkg;

    localparam int TickW       = 16;
    localparam int EvqDepthDef = 4;

    localparam logic [TickW-1:0] LockoutRst = 16'd150;
    localparam logic [TickW-1:0] ClickRst   = 16'd500;
    localparam logic [TickW-1:0] HoldRst    = 16'd1500;
    localparam logic [TickW-1:0] TagRst     = 16'd0;

    // Second press of a gesture is a double click.
    localparam logic [1:0] DoubleCount = 2'd2;

    typedef enum logic [1:0] {
        EV_SINGLE = 2'd0,
        EV_DOUBLE = 2'd1,
        EV_HOLD   = 2'd2
    } t_evt_code;

    typedef enum logic [1:0] {
        REG_LOCKOUT = 2'd0,
        REG_CLICK   = 2'd1,
        REG_HOLD    = 2'd2,
        REG_TAG     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [TickW-1:0] lockout_ticks;
        logic [TickW-1:0] click_ticks;
        logic [TickW-1:0] hold_ticks;
        logic [TickW-1:0] source_tag;
    } t_cfg;

    typedef struct packed {
        logic             prior_level;
        logic [TickW-1:0] lockout_left;
        logic [TickW-1:0] click_left;
        logic             click_running;
        logic [TickW-1:0] hold_left;
        logic             hold_running;
        logic [1:0]       press_count;
        logic             hold_seen;
    } t_state;

    typedef struct packed {
        t_evt_code        code;
        logic [TickW-1:0] source;
        logic             last;
    } t_event;

    // Up to two events per tick, packed so that evt_a is always the first one.
    typedef struct packed {
        logic [1:0] n_evt;
        t_event     evt_a;
        t_event     evt_b;
    } t_step_res;

    // A tick count of zero behaves as one.
    function automatic logic [TickW-1:0] at_least_one(input logic [TickW-1:0] v);
        return (v == '0) ? TickW'(1) : v;
    endfunction

endpackage

// File: rtl/bgc_step.sv
module bgc_step
    import bgc_pkg::*;
(
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    input  logic      i_pin_level,
    output t_state    o_state,
    output t_step_res o_res
);

    always_comb begin
        t_state    s;
        logic      single_hit;
        logic      second_hit;
        t_evt_code second_code;
        t_event    ev_single;
        t_event    ev_second;

        s           = i_state;
        single_hit  = 1'b0;
        second_hit  = 1'b0;
        second_code = EV_DOUBLE;

        // Click window first: a lone press that outlives it is a single click.
        if (s.click_running) begin
            s.click_left = s.click_left - TickW'(1);
            if (s.click_left == '0) begin
                s.click_running = 1'b0;
                if (s.press_count == 2'd1) begin
                    single_hit     = 1'b1;
                    s.press_count  = 2'd0;
                    s.hold_running = 1'b0;
                    s.hold_left    = '0;
                end
            end
        end

        if (s.hold_running) begin
            s.hold_left = s.hold_left - TickW'(1);
            if (s.hold_left == '0) begin
                s.hold_running = 1'b0;
                s.hold_seen    = 1'b1;
            end
        end

        if (s.lockout_left != '0) begin
            s.lockout_left = s.lockout_left - TickW'(1);
            if (s.lockout_left == '0) begin
                if (s.press_count == 2'd0) begin
                    s.click_left    = at_least_one(i_cfg.click_ticks);
                    s.click_running = 1'b1;
                    s.hold_left     = at_least_one(i_cfg.hold_ticks);
                    s.hold_running  = 1'b1;
                end
                if (i_pin_level && s.press_count != 2'd3) begin
                    s.press_count = s.press_count + 2'd1;
                end
                if (s.press_count >= DoubleCount) begin
                    second_hit      = 1'b1;
                    second_code     = EV_DOUBLE;
                    s.press_count   = 2'd0;
                    s.click_running = 1'b0;
                    s.click_left    = '0;
                    s.hold_running  = 1'b0;
                    s.hold_left     = '0;
                end
                if (s.hold_seen && s.press_count == 2'd1) begin
                    second_hit      = 1'b1;
                    second_code     = EV_HOLD;
                    s.press_count   = 2'd0;
                    s.hold_seen     = 1'b0;
                    s.click_running = 1'b0;
                    s.click_left    = '0;
                    s.hold_running  = 1'b0;
                    s.hold_left     = '0;
                end
            end
        end else if (i_pin_level != s.prior_level) begin
            s.lockout_left = at_least_one(i_cfg.lockout_ticks);
        end

        s.prior_level = i_pin_level;

        ev_single.code   = EV_SINGLE;
        ev_single.source = i_cfg.source_tag;
        ev_single.last   = !second_hit;
        ev_second.code   = second_code;
        ev_second.source = i_cfg.source_tag;
        ev_second.last   = 1'b1;

        o_state     = s;
        o_res.n_evt = {1'b0, single_hit} + {1'b0, second_hit};
        o_res.evt_a = single_hit ? ev_single : ev_second;
        o_res.evt_b = ev_second;
    end

endmodule

// File: rtl/bgc_evq.sv
module bgc_evq
    import bgc_pkg::*;
#(
    parameter int Depth = EvqDepthDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_n_push,
    input  t_event     i_evt_a,
    input  t_event     i_evt_b,
    output logic       o_room2,
    output logic       o_valid,
    input  logic       i_ready,
    output t_event     o_evt
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);

    t_event        r_slot [Depth];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] n_cnt;
    logic [AW-1:0] wr_1;
    logic [AW-1:0] wr_2;
    logic          pop;

    assign wr_1 = (r_wr == LastIdx) ? '0 : r_wr + AW'(1);
    assign wr_2 = (wr_1 == LastIdx) ? '0 : wr_1 + AW'(1);

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_evt   = r_slot[r_rd];
    assign o_room2 = (r_cnt <= CW'(Depth - 2));

    always_comb begin
        n_rd = r_rd;
        if (pop) begin
            n_rd = (r_rd == LastIdx) ? '0 : r_rd + AW'(1);
        end
        case (i_n_push)
            2'd0:    n_wr = r_wr;
            2'd1:    n_wr = wr_1;
            default: n_wr = wr_2;
        endcase
        n_cnt = r_cnt + CW'(i_n_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_n_push != 2'd0) begin
            r_slot[r_wr] <= i_evt_a;
        end
        if (i_n_push >= 2'd2) begin
            r_slot[wr_1] <= i_evt_b;
        end
    end

endmodule

// File: rtl/button_gesture_classifier.sv
// Channel   Direction  Handshake                   Payload
// --------  ---------  --------------------------  -------------------------------------
// tick in   input      i_in_valid / o_in_ready     i_pin_level
// events    output     o_out_valid / i_out_ready   o_event_code, o_event_source,
//                                                  o_last_event
// config    APB        psel, penable, pwrite, ...  paddr, pwdata, prdata
//
// Each tick transaction is folded into the gesture state in the cycle it is accepted,
// so one tick per clock is taken while o_in_ready is high. The single-pass update logic
// (three down counters and their compares) sets that figure. A tick yields zero, one or
// two events, which enter a small event queue; one event leaves per cycle while
// i_out_ready is high. o_in_ready is high while the queue has room for two events,
// so a stalled output side only stops the input once fewer than two slots are free.
// i_rst_n is synchronous and active low; it restores the registers to their defaults
// and clears the gesture state and the queue.
module button_gesture_classifier
    import bgc_pkg::*;
#(
    parameter int EvqDepth = EvqDepthDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Tick input channel.
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_pin_level,
    // Event output channel.
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [1:0]       o_event_code,
    output logic [TickW-1:0] o_event_source,
    output logic             o_last_event,
    // Configuration port.
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_cfg      r_cfg;
    t_state    r_state;
    t_state    n_state;
    t_step_res step_res;
    t_event    out_evt;
    t_reg_idx  reg_idx;
    logic      cfg_wr;
    logic      tick_acc;
    logic      room2;
    logic [1:0] tick_push;

    // Registers sit at word addresses; the low two address bits are ignored.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_ticks <= LockoutRst;
            r_cfg.click_ticks   <= ClickRst;
            r_cfg.hold_ticks    <= HoldRst;
            r_cfg.source_tag    <= TagRst;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LOCKOUT: r_cfg.lockout_ticks <= pwdata[TickW-1:0];
                REG_CLICK:   r_cfg.click_ticks   <= pwdata[TickW-1:0];
                REG_HOLD:    r_cfg.hold_ticks    <= pwdata[TickW-1:0];
                REG_TAG:     r_cfg.source_tag    <= pwdata[TickW-1:0];
                default:     r_cfg               <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LOCKOUT: prdata = {16'd0, r_cfg.lockout_ticks};
            REG_CLICK:   prdata = {16'd0, r_cfg.click_ticks};
            REG_HOLD:    prdata = {16'd0, r_cfg.hold_ticks};
            REG_TAG:     prdata = {16'd0, r_cfg.source_tag};
            default:     prdata = '0;
        endcase
    end

    // The state advances only on an accepted tick; idle cycles leave the timers alone.
    assign o_in_ready = room2;
    assign tick_acc   = i_in_valid && o_in_ready;

    bgc_step u_step (
        .i_state     (r_state),
        .i_cfg       (r_cfg),
        .i_pin_level (i_pin_level),
        .o_state     (n_state),
        .o_res       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.prior_level   <= 1'b1;
            r_state.lockout_left  <= '0;
            r_state.click_left    <= '0;
            r_state.click_running <= 1'b0;
            r_state.hold_left     <= '0;
            r_state.hold_running  <= 1'b0;
            r_state.press_count   <= 2'd0;
            r_state.hold_seen     <= 1'b0;
        end else if (tick_acc) begin
            r_state <= n_state;
        end
    end

    assign tick_push = tick_acc ? step_res.n_evt : 2'd0;

    // The queue is the output register: results wait there and hold up ticks only when fewer than two slots are free.
    bgc_evq #(
        .Depth (EvqDepth)
    ) u_evq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_n_push (tick_push),
        .i_evt_a  (step_res.evt_a),
        .i_evt_b  (step_res.evt_b),
        .o_room2  (room2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_evt    (out_evt)
    );

    assign o_event_code   = out_evt.code;
    assign o_event_source = out_evt.source;
    assign o_last_event   = out_evt.last;

endmodule
